### sv/assert_macros.svh
// Assertion macros for the verification files of the prescaled period timer.
// No dependencies; included by the checker that is bound to the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### sv/ppt_pkg.sv
// Types, codes and constant tables of the prescaled period timer.
// No dependencies; used by the core, the output buffer and the top level.
package ppt_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_COUNT   = 2'd1;
  localparam logic [1:0] SEL_PERIOD  = 2'd2;

  localparam logic [1:0] WMODE_PLAIN  = 2'd0;
  localparam logic [1:0] WMODE_CLEAR  = 2'd1;
  localparam logic [1:0] WMODE_SET    = 2'd2;
  localparam logic [1:0] WMODE_INVERT = 2'd3;

  localparam int CTL_ON_BIT  = 15;
  localparam int CTL_EXT_BIT = 1;
  localparam int CTL_PS_LSB  = 4;
  localparam int PS_CODE_W   = 3;

  // Terminal prescale count (divisor minus one) for each prescaler code.
  localparam logic [7:0] FULL_LAST [8] = '{8'd0, 8'd1, 8'd3, 8'd7,
                                           8'd15, 8'd31, 8'd63, 8'd255};
  localparam logic [7:0] REDUCED_LAST [8] = '{8'd0, 8'd7, 8'd63, 8'd255,
                                              8'd255, 8'd255, 8'd255, 8'd255};

  typedef struct packed {
    logic [15:0] read_data;
    logic        period_match;
  } ppt_result_t;

  // Bus write with plain, clear, set and invert modes on a 32-bit view.
  function automatic logic [31:0] apply_write(logic [31:0] old_value, logic [1:0] mode,
                                              logic [31:0] data);
    logic [31:0] res;
    unique case (mode)
      WMODE_PLAIN:  res = data;
      WMODE_CLEAR:  res = old_value & ~data;
      WMODE_SET:    res = old_value | data;
      WMODE_INVERT: res = old_value ^ data;
      default:      res = data;
    endcase
    return res;
  endfunction

endpackage

### sv/ppt_if.sv
// Channel interfaces of the prescaled period timer: command items in, result items out.
// No dependencies.
interface ppt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  reg_select;
  logic [1:0]  write_mode;
  logic [15:0] write_data;
  logic        external_edge;

  modport source (output valid, kind, reg_select, write_mode, write_data, external_edge,
                  input ready);
  modport sink (input valid, kind, reg_select, write_mode, write_data, external_edge,
                output ready);
endinterface

interface ppt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        period_match;

  modport source (output valid, read_data, period_match, input ready);
  modport sink (input valid, read_data, period_match, output ready);
endinterface

### sv/ppt_core.sv
// Timer state (control, counter, period, prescaler) and the per-item update logic.
// Depends on ppt_pkg.
module ppt_core #(
  parameter int COUNT_WIDTH    = 16,
  parameter int PRESCALE_CODES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  logic                 fire,
  input  logic [1:0]           kind,
  input  logic [1:0]           reg_select,
  input  logic [1:0]           write_mode,
  input  logic [15:0]          write_data,
  input  logic                 external_edge,
  output ppt_pkg::ppt_result_t result
);

  logic                   reduced_set;
  logic [15:0]            control_word;
  logic [COUNT_WIDTH-1:0] count_value;
  logic [COUNT_WIDTH-1:0] period_value;
  logic [7:0]             prescale_count;

  logic [15:0]            control_word_next;
  logic [COUNT_WIDTH-1:0] count_value_next;
  logic [COUNT_WIDTH-1:0] period_value_next;
  logic [7:0]             prescale_count_next;

  logic [ppt_pkg::PS_CODE_W-1:0] code;
  logic [ppt_pkg::PS_CODE_W-1:0] code_eff;
  logic [7:0]                    last;
  logic                          advance;
  logic [31:0]                   ctl_written;
  logic [31:0]                   cnt_written;
  logic [31:0]                   per_written;

  assign code = control_word[ppt_pkg::CTL_PS_LSB +: ppt_pkg::PS_CODE_W];

  // With the full set selected, codes beyond the implemented set use the last implemented code.
  always_comb begin
    code_eff = code;
    if (!reduced_set && (32'(code) >= PRESCALE_CODES)) begin
      code_eff = ppt_pkg::PS_CODE_W'(PRESCALE_CODES - 1);
    end
  end

  assign last = reduced_set ? ppt_pkg::REDUCED_LAST[code_eff] : ppt_pkg::FULL_LAST[code_eff];

  assign advance = (kind == ppt_pkg::KIND_TICK) && control_word[ppt_pkg::CTL_ON_BIT] &&
                   (!control_word[ppt_pkg::CTL_EXT_BIT] || external_edge);

  assign ctl_written = ppt_pkg::apply_write(32'(control_word), write_mode, 32'(write_data));
  assign cnt_written = ppt_pkg::apply_write(32'(count_value), write_mode, 32'(write_data));
  assign per_written = ppt_pkg::apply_write(32'(period_value), write_mode, 32'(write_data));

  always_comb begin
    control_word_next   = control_word;
    count_value_next    = count_value;
    period_value_next   = period_value;
    prescale_count_next = prescale_count;
    result              = '0;
    unique case (kind)
      ppt_pkg::KIND_TICK: begin
        if (advance) begin
          if (prescale_count >= last) begin
            prescale_count_next = '0;
            if (count_value == period_value) begin
              count_value_next    = '0;
              result.period_match = 1'b1;
            end else begin
              count_value_next = count_value + COUNT_WIDTH'(1);
            end
          end else begin
            prescale_count_next = prescale_count + 8'd1;
          end
        end
      end
      ppt_pkg::KIND_WRITE: begin
        unique case (reg_select)
          ppt_pkg::SEL_CONTROL: begin
            control_word_next = ctl_written[15:0];
            if (!ctl_written[ppt_pkg::CTL_ON_BIT]) begin
              prescale_count_next = '0;
            end
          end
          ppt_pkg::SEL_COUNT: begin
            count_value_next    = cnt_written[COUNT_WIDTH-1:0];
            prescale_count_next = '0;
          end
          ppt_pkg::SEL_PERIOD: begin
            period_value_next = per_written[COUNT_WIDTH-1:0];
          end
          default: begin
          end
        endcase
      end
      ppt_pkg::KIND_READ: begin
        unique case (reg_select)
          ppt_pkg::SEL_CONTROL: result.read_data = control_word;
          ppt_pkg::SEL_COUNT:   result.read_data = 16'(count_value);
          ppt_pkg::SEL_PERIOD:  result.read_data = 16'(period_value);
          default:              result.read_data = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reduced_set    <= 1'b0;
      control_word   <= '0;
      count_value    <= '0;
      period_value   <= '1;
      prescale_count <= '0;
    end else begin
      if (cfg_we) begin
        reduced_set <= cfg_data;
      end
      if (fire) begin
        control_word   <= control_word_next;
        count_value    <= count_value_next;
        period_value   <= period_value_next;
        prescale_count <= prescale_count_next;
      end
    end
  end

endmodule

### sv/ppt_skid.sv
// Result register with a skid stage, so a stalled result does not stop the next transfer.
// Depends on ppt_pkg and the ppt_rsp_if interface.
module ppt_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ppt_pkg::ppt_result_t data,
  output logic                 accept_ok,
  ppt_rsp_if.source            rsp
);

  logic                 out_valid;
  logic                 skid_valid;
  ppt_pkg::ppt_result_t out_data;
  ppt_pkg::ppt_result_t skid_data;
  logic                 pop;

  assign pop       = out_valid && rsp.ready;
  assign accept_ok = !skid_valid;

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_data.read_data;
  assign rsp.period_match = out_data.period_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (push && out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else if (push) begin
        out_valid <= 1'b1;
      end else begin
        out_valid <= out_valid && !pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && pop) begin
      out_data <= skid_data;
    end else if (!skid_valid && push && (!out_valid || pop)) begin
      out_data <= data;
    end
    if (!skid_valid && push && out_valid && !pop) begin
      skid_data <= data;
    end
  end

endmodule

### sv/prescaled_period_timer.sv
// Prescaled period timer: one result transfer for every command transfer, in order.
// A result is registered at its command's transfer, in the skid stage if rsp stalls.
// Throughput: one command per cycle; cmd.ready drops only when the result register
// and its skid stage are both full because rsp is stalled.
// Reset (rst, synchronous, active high): timer off, counter and prescaler zero,
// period all ones, full prescaler set selected, no result pending.
module prescaled_period_timer #(
  parameter int COUNT_WIDTH    = 16,
  parameter int PRESCALE_CODES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  ppt_cmd_if.sink   cmd,
  ppt_rsp_if.source rsp
);

  // A command transfer updates the timer state at the same edge at which its
  // result is captured, so every command sees the state left by the one before.
  logic                 fire;
  logic                 accept_ok;
  ppt_pkg::ppt_result_t result;

  assign cmd.ready = accept_ok;
  assign fire      = cmd.valid && accept_ok;

  // The core holds the control word, counter, period and prescaler, and works out
  // both the next state and the result of the command now on cmd.
  ppt_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .PRESCALE_CODES (PRESCALE_CODES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fire          (fire),
    .kind          (cmd.kind),
    .reg_select    (cmd.reg_select),
    .write_mode    (cmd.write_mode),
    .write_data    (cmd.write_data),
    .external_edge (cmd.external_edge),
    .result        (result)
  );

  // The result register plus skid stage keeps cmd.ready high for one extra
  // transfer while the consumer of rsp holds off.
  ppt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .data      (result),
    .accept_ok (accept_ok),
    .rsp       (rsp)
  );

endmodule

### sv/ppt_checker.sv
// Port-level checks of the prescaled period timer, bound to the top level.
// Depends on assert_macros.svh, ppt_pkg and the top-level module prescaled_period_timer.
`include "assert_macros.svh"

module ppt_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [1:0]  cmd_kind,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_read_data,
  input logic        rsp_period_match
);

  `ASSERT_CLK_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_period_match), "stalled result changed")
  `ASSERT_CLK_RST(a_ready_when_empty, clk, rst, !rsp_valid |-> cmd_ready, "command stalled with no result pending")
  `ASSERT_CLK_RST(a_result_follows, clk, rst, cmd_valid && cmd_ready && !rsp_valid |=> rsp_valid, "transfer produced no result")
  `ASSERT_CLK_RST(a_tick_no_data, clk, rst, cmd_valid && cmd_ready && !rsp_valid && cmd_kind == ppt_pkg::KIND_TICK |=> rsp_read_data == 16'd0, "tick result carries read data")
  `ASSERT_NEVER(a_match_xor_data, clk, rst, rsp_valid && rsp_period_match && rsp_read_data != 16'd0, "match and read data in one result")

endmodule

bind prescaled_period_timer ppt_checker u_ppt_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_kind         (cmd.kind),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_read_data    (rsp.read_data),
  .rsp_period_match (rsp.period_match)
);
